// ===== rtl/core/arpv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpv_pkg
// Shared types, constants and helpers for the audio ring playout core.
// ----------------------------------------------------------------------------
package arpv_pkg;

    localparam int DEF_RING_DEPTH     = 1024;
    localparam int DEF_PACKET_SAMPLES = 32;
    localparam int DEF_PACKET_COUNT   = 4;
    localparam int DEF_QUEUE_DEPTH    = 4;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 17;
    localparam int TICK_W   = 10;
    localparam int ACC_W    = 26;
    localparam int DAC_W    = 10;
    localparam int LEVEL_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME      = 2'd2;

    localparam logic              ACTION_TICK  = 1'b0;
    localparam logic              ACTION_WRITE = 1'b1;

    localparam logic [15:0]       MIDSCALE     = 16'h8000;
    localparam logic [15:0]       VOL_SILENCE  = 16'h8000;
    localparam logic [15:0]       VOL_MAX      = 16'd256;
    localparam logic [7:0]        POT_HI_MASK  = 8'hF8;
    localparam logic [7:0]        POT_LO_MASK  = 8'h08;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 3'd7;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
        logic [15:0]                pot_reading;
    } in_word_t;

    typedef struct packed {
        logic [DAC_W-1:0]   dac_code;
        logic               vu_valid;
        logic [LEVEL_W-1:0] vu_level;
    } out_word_t;

    // One tick on its way from the front to the back.
    typedef struct packed {
        logic                       play;
        logic                       mute;
        logic                       vu_update;
        logic [GAIN_W-1:0]          gain;
        logic signed [SAMPLE_W-1:0] sample;
    } tick_desc_t;

    // Gain from host volume and pot reading; silence code gives zero.
    function automatic logic [GAIN_W-1:0] calc_gain(input logic [15:0] vol,
                                                    input logic [15:0] reading);
        logic [8:0]  vol_c;
        logic [8:0]  pot;
        logic [17:0] prod;
        vol_c = (vol > VOL_MAX) ? VOL_MAX[8:0] : vol[8:0];
        pot   = 9'(reading[15:8] & POT_HI_MASK) + 9'(reading[14:7] & POT_LO_MASK);
        prod  = 18'(vol_c) * 18'(pot);
        if (vol == VOL_SILENCE)
        begin
            return '0;
        end
        return prod[GAIN_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/arpv_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arpv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/arpv_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpv_front
// Accept words, store samples, run the ring indexes, tick counter and gain.
// ----------------------------------------------------------------------------
module arpv_front #(
    parameter int RING_DEPTH     = 1024,
    parameter int PACKET_SAMPLES = 32,
    parameter int PACKET_COUNT   = 4,
    parameter int QUEUE_DEPTH    = 4
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    input  wire arpv_pkg::in_word_t               item,
    output logic                                  full,
    input  wire logic                             play_enable,
    input  wire logic                             mute,
    input  wire logic [15:0]                      volume_setting,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] q_free,
    output logic                                  q_push,
    output arpv_pkg::tick_desc_t                  q_desc
);
    import arpv_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int FREE_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [31:0] LOW_FILL  = 32'(PACKET_COUNT * PACKET_SAMPLES);
    localparam logic [31:0] SLIP_FILL = 32'(RING_DEPTH) - LOW_FILL;

    logic [IDX_W-1:0]  write_index_reg, write_index_next;
    logic [IDX_W-1:0]  read_index_reg,  read_index_next;
    logic [CNT_W-1:0]  wr_count_reg,    wr_count_next;
    logic [TICK_W-1:0] tick_count_reg,  tick_count_next;
    logic [GAIN_W-1:0] gain_reg,        gain_next;
    logic              s1_valid_reg;
    logic              s1_ok_reg;
    tick_desc_t        s1_desc_reg;

    logic              accept;
    logic              is_tick;
    logic              is_write;
    logic              rd_en;
    logic              rd_ok;
    logic [IDX_W-1:0]  fill;
    logic [31:0]       fill32;
    logic              step_over;
    logic              step_slip;
    logic [SAMPLE_W-1:0] ram_q;

    // Reserve a queue slot for the word still waiting on RAM data.
    assign full = (q_free == FREE_W'(0)) || ((q_free == FREE_W'(1)) && s1_valid_reg);

    assign accept   = push && !full;
    assign is_tick  = accept && (item.action == ACTION_TICK);
    assign is_write = accept && (item.action == ACTION_WRITE);
    assign rd_en    = is_tick && play_enable;

    assign fill      = write_index_reg - read_index_reg;
    assign fill32    = 32'(fill);
    assign step_over = fill32 > LOW_FILL;
    assign step_slip = fill32 == SLIP_FILL;

    // Ring fills from entry zero upward; anything at or past the count reads as zero.
    assign rd_ok = wr_count_reg > {1'b0, read_index_reg};

    always_comb
    begin
        write_index_next = write_index_reg;
        read_index_next  = read_index_reg;
        wr_count_next    = wr_count_reg;
        tick_count_next  = tick_count_reg;
        gain_next        = gain_reg;
        if (is_write)
        begin
            write_index_next = write_index_reg + IDX_W'(1);
            if (wr_count_reg != CNT_W'(RING_DEPTH))
            begin
                wr_count_next = wr_count_reg + CNT_W'(1);
            end
        end
        if (is_tick)
        begin
            if (play_enable)
            begin
                read_index_next = read_index_reg + IDX_W'(step_over) + IDX_W'(step_slip);
            end
            if (tick_count_reg == '0)
            begin
                gain_next = calc_gain(volume_setting, item.pot_reading);
            end
            tick_count_next = tick_count_reg + TICK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg <= '0;
            read_index_reg  <= '0;
            wr_count_reg    <= '0;
            tick_count_reg  <= '0;
            gain_reg        <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            write_index_reg <= write_index_next;
            read_index_reg  <= read_index_next;
            wr_count_reg    <= wr_count_next;
            tick_count_reg  <= tick_count_next;
            gain_reg        <= gain_next;
            s1_valid_reg    <= is_tick;
        end
    end

    // Hold the tick's context while the ring read completes.
    always_ff @(posedge clk)
    begin
        if (is_tick)
        begin
            s1_ok_reg             <= rd_ok && play_enable;
            s1_desc_reg.play      <= play_enable;
            s1_desc_reg.mute      <= mute;
            s1_desc_reg.vu_update <= (tick_count_reg == '0);
            s1_desc_reg.gain      <= gain_reg;
            s1_desc_reg.sample    <= '0;
        end
    end

    arpv_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (is_write),
        .waddr (write_index_reg),
        .wdata (item.sample),
        .re    (rd_en),
        .raddr (read_index_reg),
        .rdata (ram_q)
    );

    always_comb
    begin
        q_desc        = s1_desc_reg;
        q_desc.sample = s1_ok_reg ? $signed(ram_q) : '0;
    end

    assign q_push = s1_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/core/arpv_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpv_queue
// Short FIFO of tick descriptors between front and back.
// ----------------------------------------------------------------------------
module arpv_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire arpv_pkg::tick_desc_t       wr_desc,
    input  wire logic                       rd_en,
    output logic                            rd_valid,
    output arpv_pkg::tick_desc_t            rd_desc,
    output logic [$clog2(DEPTH+1)-1:0]      free
);
    import arpv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tick_desc_t       slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_rd;

    assign do_rd    = rd_en && (count_reg != '0);
    assign rd_valid = count_reg != '0;
    assign rd_desc  = slots[rd_ptr_reg];
    assign free     = CNT_W'(DEPTH) - count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!wr_en && do_rd)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/arpv_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpv_back
// Scale the sample, meter it and present the DAC word on the result port.
// ----------------------------------------------------------------------------
module arpv_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire arpv_pkg::tick_desc_t q_desc,
    output logic                      q_pop,
    output logic                      empty,
    input  wire logic                 pop,
    output arpv_pkg::out_word_t       result
);
    import arpv_pkg::*;

    logic                 b1_valid_reg;
    logic [15:0]          b1_hi_reg;
    logic                 b1_mid_reg;
    logic                 b1_vu_reg;
    logic [LEVEL_W-1:0]   b1_level_reg;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic                 out_valid_reg;
    out_word_t            result_reg;

    logic                 out_ready;
    logic                 b1_adv;
    logic                 b1_ready;
    logic signed [33:0]   prod;
    logic [15:0]          mag;
    logic [ACC_W-1:0]     acc_sum;
    logic [LEVEL_W-1:0]   level;
    logic [15:0]          word;

    assign out_ready = !out_valid_reg || pop;
    assign b1_adv    = b1_valid_reg && out_ready;
    assign b1_ready  = !b1_valid_reg || b1_adv;
    assign q_pop     = q_valid && b1_ready;

    assign prod = $signed(q_desc.sample) * $signed({1'b0, q_desc.gain});
    assign mag  = q_desc.sample[15] ? (~q_desc.sample + 16'd1) : q_desc.sample;

    always_comb
    begin
        acc_sum = q_desc.play ? (acc_reg + ACC_W'(mag)) : acc_reg;
        level   = '0;
        acc_next = acc_reg;
        if (q_pop)
        begin
            acc_next = acc_sum;
            if (q_desc.vu_update)
            begin
                level    = (acc_sum[ACC_W-1:20] > 6'(LEVEL_MAX)) ? LEVEL_MAX
                                                                 : acc_sum[22:20];
                acc_next = '0;
            end
        end
    end

    // Offset the upper product half by midscale; stopped or muted gives midscale.
    assign word = b1_mid_reg ? MIDSCALE : (b1_hi_reg ^ MIDSCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (b1_ready)
            begin
                b1_valid_reg <= q_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= b1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_hi_reg    <= prod[31:16];
            b1_mid_reg   <= !q_desc.play || q_desc.mute;
            b1_vu_reg    <= q_desc.vu_update;
            b1_level_reg <= level;
        end
        if (b1_adv)
        begin
            result_reg.dac_code <= word[15:6];
            result_reg.vu_valid <= b1_vu_reg;
            result_reg.vu_level <= b1_level_reg;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== rtl/core/audio_ring_playout_volume_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_ring_playout_volume_core
// Sample ring playout with rate slip, pot-controlled gain and VU metering.
// ----------------------------------------------------------------------------
// Usage:
//   Input words go in through push/full: action=1 stores a sample in the ring,
//   action=0 is a playout tick. A word is taken on a rising edge with push high
//   and full low. Each tick yields one result word (dac_code, vu_valid,
//   vu_level) on the result side, read through empty/pop; writes yield none.
//   One word is taken every cycle while the tick queue has room.
//   When the receiver keeps up, a taken tick's result passes the ring RAM
//   read register, is written into the tick queue, then moves from the tick
//   queue into the gain multiplier register and on into the result register.
//   The queue depth does not lengthen this path.
//   When the receiver stalls, the result register holds, the queue fills and
//   full rises; writes and ticks then wait together.
//   The user writes configuration (play_enable, mute, volume_setting) through
//   cfg_we/cfg_index/cfg_data only while idle; the core does not enforce this.
//   Unused indexes are dropped. Reset clears indexes, counters, gain, meter and
//   registers at once. The ring needs no clearing pass: a fill count marks
//   entries written since reset, and any other entry plays as zero.
// ----------------------------------------------------------------------------
module audio_ring_playout_volume_core #(
    parameter int RING_DEPTH     = arpv_pkg::DEF_RING_DEPTH,
    parameter int PACKET_SAMPLES = arpv_pkg::DEF_PACKET_SAMPLES,
    parameter int PACKET_COUNT   = arpv_pkg::DEF_PACKET_COUNT,
    parameter int QUEUE_DEPTH    = arpv_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    input  wire arpv_pkg::in_word_t                  item,
    output logic                                     full,
    output logic                                     empty,
    input  wire logic                                pop,
    output arpv_pkg::out_word_t                      result,
    input  wire logic                                cfg_we,
    input  wire logic [arpv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [arpv_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import arpv_pkg::*;

    localparam int FREE_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration registers.
    logic        play_enable_reg, play_enable_next;
    logic        mute_reg,        mute_next;
    logic [15:0] volume_reg,      volume_next;

    // Front to queue, queue to back.
    logic              q_push;
    tick_desc_t        q_wr_desc;
    logic              q_pop;
    logic              q_valid;
    tick_desc_t        q_rd_desc;
    logic [FREE_W-1:0] q_free;

    // Decode a register write; drop indexes past the list.
    always_comb
    begin
        play_enable_next = play_enable_reg;
        mute_next        = mute_reg;
        volume_next      = volume_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PLAY_ENABLE: play_enable_next = cfg_data[0];
                CFG_MUTE:        mute_next        = cfg_data[0];
                CFG_VOLUME:      volume_next      = cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_enable_reg <= 1'b0;
            mute_reg        <= 1'b0;
            volume_reg      <= '0;
        end
        else
        begin
            play_enable_reg <= play_enable_next;
            mute_reg        <= mute_next;
            volume_reg      <= volume_next;
        end
    end

    // Front: take words, store samples, read the ring, advance indexes and gain.
    arpv_front #(
        .RING_DEPTH     (RING_DEPTH),
        .PACKET_SAMPLES (PACKET_SAMPLES),
        .PACKET_COUNT   (PACKET_COUNT),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .item           (item),
        .full           (full),
        .play_enable    (play_enable_reg),
        .mute           (mute_reg),
        .volume_setting (volume_reg),
        .q_free         (q_free),
        .q_push         (q_push),
        .q_desc         (q_wr_desc)
    );

    // Queue: decouple the front from a stalled result side.
    arpv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_desc  (q_wr_desc),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_desc  (q_rd_desc),
        .free     (q_free)
    );

    // Back: scale, meter and hold the result until popped.
    arpv_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_desc  (q_rd_desc),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
`default_nettype wire

// ===== rtl/core/arpv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpv_checker
// Port-level checks on the playout core, bound to the top level.
// ----------------------------------------------------------------------------
module arpv_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    input  wire arpv_pkg::in_word_t              item,
    input  wire logic                            full,
    input  wire logic                            empty,
    input  wire logic                            pop,
    input  wire arpv_pkg::out_word_t             result,
    input  wire logic                            cfg_we,
    input  wire logic [arpv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [arpv_pkg::CFG_DATA_W-1:0] cfg_data
);
    import arpv_pkg::*;

    logic took_word;
    logic cfg_touch;

    assign took_word = push && !full;
    assign cfg_touch = cfg_we && (cfg_index != CFG_PLAY_ENABLE || cfg_data != '0);

    // Hold a waiting result word while the receiver stalls.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result word changed while stalled");

    // Level is only reported on meter update ticks.
    a_level_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.vu_valid) |-> (result.vu_level == '0))
        else $error("vu_level nonzero without vu_valid");

    // Backpressure only grows when a word is taken.
    a_full_rise: assert property (@(posedge clk) disable iff (!rst_n)
        (!took_word && !cfg_touch) |=> !$rose(full))
        else $error("full rose without an accepted word");

endmodule

bind audio_ring_playout_volume_core arpv_checker u_checker (.*);
`default_nettype wire

// ===== tb/sv/arpv_playout_sb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpv_playout_sb_pkg
// Scoreboard for the audio ring playout core: mirrors the ring, the rate-slip
// read pointer, the gain and the VU meter, and checks every result word.
// ----------------------------------------------------------------------------
package arpv_playout_sb_pkg;
    import arpv_pkg::*;

    localparam int IDX_W       = $clog2(DEF_RING_DEPTH);
    localparam int LOW_FILL    = DEF_PACKET_COUNT * DEF_PACKET_SAMPLES;
    localparam int SLIP_FILL   = DEF_RING_DEPTH - LOW_FILL;
    localparam int PRINT_LIMIT = 60;

    class playout_scoreboard;
        logic [SAMPLE_W-1:0] ring [DEF_RING_DEPTH];
        logic [IDX_W-1:0]    wr_pos;
        logic [IDX_W-1:0]    rd_pos;
        logic [TICK_W-1:0]   tick_cnt;
        logic [ACC_W-1:0]    level_sum;
        logic [GAIN_W-1:0]   gain;
        logic                play_on;
        logic                mute_on;
        logic [15:0]         volume;
        out_word_t           dac_due [$];
        int unsigned         words_checked;
        int unsigned         mismatches;

        function new();
            foreach (ring[i])
            begin
                ring[i] = '0;
            end
            wr_pos        = '0;
            rd_pos        = '0;
            tick_cnt      = '0;
            level_sum     = '0;
            gain          = '0;
            play_on       = 1'b0;
            mute_on       = 1'b0;
            volume        = '0;
            words_checked = 0;
            mismatches    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PLAY_ENABLE: play_on = data[0];
                CFG_MUTE:        mute_on = data[0];
                CFG_VOLUME:      volume  = data;
                default:         ;
            endcase
        endfunction

        // Play one tick: read, slip, meter, scale, then the periodic gain load.
        function out_word_t play_tick(logic [15:0] reading);
            out_word_t               res;
            logic signed [15:0]      s;
            logic [15:0]             mag;
            logic [IDX_W-1:0]        fill;
            logic signed [33:0]      prod;
            logic [15:0]             dac;
            logic [8:0]              vol_c;
            logic [8:0]              pot;
            res = '0;
            dac = MIDSCALE;
            if (play_on)
            begin
                s    = ring[rd_pos];
                fill = wr_pos - rd_pos;
                if (fill == IDX_W'(SLIP_FILL))
                begin
                    rd_pos = rd_pos + 1'b1;
                end
                if (fill > LOW_FILL)
                begin
                    rd_pos = rd_pos + 1'b1;
                end
                mag       = s[15] ? 16'(-s) : 16'(s);
                level_sum = level_sum + ACC_W'(mag);
                prod      = s * $signed({1'b0, gain});
                dac       = prod[31:16] + MIDSCALE;
            end
            if (mute_on)
            begin
                dac = MIDSCALE;
            end
            if (tick_cnt == '0)
            begin
                vol_c = (volume > VOL_MAX) ? VOL_MAX[8:0] : volume[8:0];
                pot   = {1'b0, reading[15:11], 3'b000} + {5'b0, reading[10], 3'b000};
                gain  = (volume == VOL_SILENCE) ? '0 : vol_c * pot;
                res.vu_valid = 1'b1;
                res.vu_level = ((level_sum >> 20) > LEVEL_MAX) ? LEVEL_MAX
                                                               : level_sum[22:20];
                level_sum = '0;
            end
            tick_cnt     = tick_cnt + 1'b1;
            res.dac_code = dac[15:6];
            return res;
        endfunction

        function void note_word(in_word_t w);
            if (w.action == ACTION_WRITE)
            begin
                ring[wr_pos] = w.sample;
                wr_pos       = wr_pos + 1'b1;
            end
            else
            begin
                dac_due.push_back(play_tick(w.pot_reading));
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
            begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endtask

        task check_word(out_word_t got);
            out_word_t want;
            if (dac_due.size() == 0)
            begin
                report($sformatf("result word %0d with no tick pending", words_checked));
            end
            else
            begin
                want = dac_due.pop_front();
                if (got.dac_code !== want.dac_code)
                begin
                    report($sformatf("word %0d dac_code got %0d want %0d",
                                     words_checked, got.dac_code, want.dac_code));
                end
                if (got.vu_valid !== want.vu_valid)
                begin
                    report($sformatf("word %0d vu_valid got %0b want %0b",
                                     words_checked, got.vu_valid, want.vu_valid));
                end
                if (got.vu_level !== want.vu_level)
                begin
                    report($sformatf("word %0d vu_level got %0d want %0d",
                                     words_checked, got.vu_level, want.vu_level));
                end
            end
            words_checked++;
        endtask

        function int unsigned pending();
            return dac_due.size();
        endfunction

        function int unsigned fill_level();
            logic [IDX_W-1:0] fill;
            fill = wr_pos - rd_pos;
            return fill;
        endfunction

        function int unsigned tick_phase();
            return tick_cnt;
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_audio_ring_playout_volume_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_ring_playout_volume_core
// Self-checking bench: streams sample writes and playout ticks into the core,
// mirrors each accepted word in a scoreboard and checks every result word.
// ----------------------------------------------------------------------------
module tb_audio_ring_playout_volume_core;
    import arpv_pkg::*;
    import arpv_playout_sb_pkg::*;

    localparam int STALL_PCT        = 16;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 12;
    localparam int TICKS_PER_UPDATE = 1 << TICK_W;

    // Index past the register map; the core must drop writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum int
    {
        STREAM_PACKETS,
        STREAM_FILL,
        STREAM_SCATTER
    } stream_mode_e;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    in_word_t              item      = '0;
    logic                  full;
    logic                  empty;
    logic                  pop       = 1'b0;
    out_word_t             result;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Quiet flags switch off random idling on each side for a stretch.
    bit                    tx_quiet  = 1'b0;
    bit                    rx_quiet  = 1'b0;
    int unsigned           stalled_cycles = 0;

    playout_scoreboard     sb;

    always #5 clk = ~clk;

    audio_ring_playout_volume_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Receiver: stall pop at random unless the stretch is quiet.
    always @(posedge clk)
    begin
        pop <= rx_quiet || ($urandom_range(99) >= STALL_PCT);
    end

    // Monitor: sample the handshakes with their pre-edge values, check result
    // words first (a word pushed on this edge cannot have a result yet), then
    // note the accepted input word and any register write. The watchdog counts
    // edges where neither side moves a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                sb.check_word(result);
            end
            if (push && !full)
            begin
                sb.note_word(item);
            end
            if (cfg_we)
            begin
                sb.set_reg(cfg_index, cfg_data);
            end
            if ((pop && !empty) || (push && !full))
            begin
                stalled_cycles <= 0;
            end
            else
            begin
                stalled_cycles <= stalled_cycles + 1;
            end
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic in_word_t word_of(logic action, logic [15:0] sample,
                                         logic [15:0] reading);
        in_word_t w;
        w.action      = action;
        w.sample      = sample;
        w.pot_reading = reading;
        return w;
    endfunction

    // Random word; the shift shrinks sample size so the VU level spreads out.
    function automatic in_word_t make_word(logic action, int unsigned shift);
        logic signed [15:0] s;
        logic [15:0]        reading;
        case ($urandom_range(15))
            0:       s = 16'h8000;
            1:       s = 16'h7FFF;
            2:       s = 16'h0000;
            3:       s = 16'hFFFF;
            default:
            begin
                s = 16'($urandom);
                s = s >>> shift;
            end
        endcase
        case ($urandom_range(7))
            0:       reading = 16'h0000;
            1:       reading = 16'hFFFF;
            2:       reading = 16'h0400;
            default: reading = 16'($urandom);
        endcase
        return word_of(action, s, reading);
    endfunction

    function automatic logic [15:0] pick_volume();
        case ($urandom_range(8))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return VOL_MAX;
            3:       return VOL_MAX + 16'd1;
            4:       return 16'h7FFF;
            5:       return VOL_SILENCE;
            6:       return VOL_SILENCE + 16'd1;
            7:       return 16'hFFFF;
            default: return 16'($urandom_range(256));
        endcase
    endfunction

    // Offer one word; hold push and the word until full is low at an edge.
    // Leave push high on return so back-to-back words need no extra edge.
    task automatic send_word(in_word_t w);
        while (!tx_quiet && $urandom_range(99) < STALL_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic configure(logic play, logic mute, logic [15:0] vol);
        write_reg(CFG_PLAY_ENABLE, {15'b0, play});
        write_reg(CFG_MUTE, {15'b0, mute});
        write_reg(CFG_VOLUME, vol);
        cfg_we <= 1'b0;
    endtask

    // Drop push, wait for every pending result word, then let the pipeline
    // idle before anything is reconfigured.
    task automatic settle();
        push <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One stretch of playout under a fresh random setting. Packet mode mimics
    // isochronous packets, fill mode first pushes the ring near or past full
    // so the slip point and overrun are crossed, scatter mode is plain noise.
    // The stretch ends after exactly quota ticks.
    task automatic run_stretch(stream_mode_e mode, int unsigned quota,
                               logic [15:0] vol, bit quiet);
        int unsigned  shift;
        int unsigned  left;
        int unsigned  n;
        int unsigned  target;
        settle();
        tx_quiet <= quiet;
        rx_quiet <= quiet;
        configure($urandom_range(3) != 0, $urandom_range(4) == 0, vol);
        shift = $urandom_range(8);
        left  = quota;
        if (mode == STREAM_FILL)
        begin
            target = $urandom_range(1060, 900);
            n      = (target > sb.fill_level()) ? target - sb.fill_level() : 0;
            repeat (n) send_word(make_word(ACTION_WRITE, shift));
        end
        while (left > 0)
        begin
            if (mode == STREAM_SCATTER)
            begin
                if ($urandom_range(3) == 0)
                begin
                    send_word(make_word(ACTION_WRITE, shift));
                end
                else
                begin
                    send_word(make_word(ACTION_TICK, shift));
                    left--;
                end
            end
            else
            begin
                n = $urandom_range(6);
                repeat (n) send_word(make_word(ACTION_WRITE, shift));
                n = $urandom_range(48, 16);
                if (n > left)
                begin
                    n = left;
                end
                repeat (n) send_word(make_word(ACTION_TICK, shift));
                left -= n;
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: the first tick loads gain, here at full volume with the
        // pot at its top (gain 2^16), and reads a never-written entry as zero.
        write_reg(CFG_SPARE, 16'hFFFF);
        configure(1'b1, 1'b0, VOL_MAX);
        send_word(word_of(ACTION_TICK, 16'h8000, 16'hFFFF));
        send_word(word_of(ACTION_WRITE, 16'h7FFF, 16'h0000));
        send_word(word_of(ACTION_WRITE, 16'h8000, 16'hFFFF));
        send_word(word_of(ACTION_WRITE, 16'h0000, 16'h0400));
        send_word(word_of(ACTION_WRITE, 16'hFFFF, 16'hFFFF));
        send_word(word_of(ACTION_WRITE, 16'h0001, 16'h0000));
        // Low fill: the read pointer holds, full-scale positive plays.
        send_word(word_of(ACTION_TICK, 16'h0000, 16'h0000));
        send_word(word_of(ACTION_TICK, 16'hFFFF, 16'hFFFF));
        // Mute forces midscale while playback state still moves.
        settle();
        configure(1'b1, 1'b1, VOL_MAX);
        send_word(word_of(ACTION_TICK, 16'h0000, 16'hFFFF));
        // Stopped playback with the silence code pending.
        settle();
        configure(1'b0, 1'b0, VOL_SILENCE);
        send_word(word_of(ACTION_TICK, 16'h0000, 16'h0000));
        send_word(word_of(ACTION_WRITE, 16'h8001, 16'h0000));
        send_word(word_of(ACTION_WRITE, 16'h7FFE, 16'hFFFF));
        // Volume changes act only at the next gain load, not here.
        settle();
        configure(1'b1, 1'b0, 16'h0000);
        send_word(word_of(ACTION_TICK, 16'h0000, 16'h0000));
        send_word(word_of(ACTION_TICK, 16'h0000, 16'hFFFF));

        // Fill the ring past the slip point, then play it back down through it.
        run_stretch(STREAM_FILL, 128, pick_volume(), 1'b0);
        // No idling on either side for this stretch.
        run_stretch(STREAM_SCATTER, 160, pick_volume(), 1'b1);
        // Run up to the next gain load, then cross it with a freshly picked volume
        // so the load and the VU report see a full period of metering.
        settle();
        run_stretch(STREAM_PACKETS, TICKS_PER_UPDATE - sb.tick_phase(), pick_volume(),
                    1'b0);
        run_stretch(STREAM_PACKETS, 32, pick_volume(), 1'b0);

        settle();
        if (sb.mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
